### design/ghp_pkg.sv
// ----------------------------------------------------------------------------
// ghp_pkg: shared types and constants of the generational handle pool
// Slot sizing, opcodes, statuses, memory port bundles and the tag bump rule.
// ----------------------------------------------------------------------------
`default_nettype none

package ghp_pkg;

	localparam int SLOTS      = 4096;
	localparam int CHUNK      = 256;
	localparam int SLOT_W     = 12;
	localparam int CNT_W      = 13;
	localparam int GEN_W      = 8;
	localparam int VAL_W      = 32;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 72;

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_FREE   = 2'd2,
		OP_MOVE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_STALE   = 2'd1,
		ST_FULL    = 2'd2,
		ST_BAD_SRC = 2'd3
	} status_t;

	typedef struct packed {
		logic             live;
		logic [GEN_W-1:0] tag;
		logic [VAL_W-1:0] value;
	} meta_t;

	typedef struct packed {
		logic              re;
		logic [SLOT_W-1:0] raddr;
		logic              we;
		logic [SLOT_W-1:0] waddr;
		meta_t             wdata;
	} meta_req_t;

	typedef struct packed {
		logic              re;
		logic [SLOT_W-1:0] raddr;
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [SLOT_W-1:0] wdata;
	} link_req_t;

	// next generation, skipping zero
	function automatic logic [GEN_W-1:0] bump_tag(input logic [GEN_W-1:0] t);
		logic [GEN_W-1:0] n;
		n = t + GEN_W'(1);
		return (n == '0) ? GEN_W'(1) : n;
	endfunction

endpackage

`default_nettype wire

### design/ghp_store.sv
// ----------------------------------------------------------------------------
// ghp_store: slot storage
// Metadata memory (live, tag, value) and free-list link memory, each with
// one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ghp_store
	import ghp_pkg::*;
(
	input  wire logic              clk,
	input  wire meta_req_t         meta_req,
	output      meta_t             meta_rd,
	input  wire link_req_t         link_req,
	output      logic [SLOT_W-1:0] link_rd
);

	meta_t             meta_mem [SLOTS];
	logic [SLOT_W-1:0] link_mem [SLOTS];

	always_ff @(posedge clk) begin
		if (meta_req.we) begin
			meta_mem[meta_req.waddr] <= meta_req.wdata;
		end
		if (meta_req.re) begin
			meta_rd <= meta_mem[meta_req.raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (link_req.we) begin
			link_mem[link_req.waddr] <= link_req.wdata;
		end
		if (link_req.re) begin
			link_rd <= link_mem[link_req.raddr];
		end
	end

endmodule

`default_nettype wire

### design/generational_handle_pool.sv
// ----------------------------------------------------------------------------
// generational_handle_pool: handle table with generation-tagged slots
// Allocate, lookup and free pass through S_IDLE and S_CHECK before the
// result is registered; a move adds S_MDST, plus an S_WALK/S_WCHK pair per
// free-list node walked when a freed destination must be unlinked. One
// request is in flight at a time, set by the single read port of the slot
// memory. Reset clears all control registers at once; no clearing pass, since
// slots at or above the issue mark read as never issued.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_pool
	import ghp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output      logic                  s_tready,
	// opcode[1:0], slot[13:2], generation[21:14], value[53:22],
	// src_slot[65:54], src_generation[73:66], zero fill above
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	output      logic                  m_tvalid,
	input  wire logic                  m_tready,
	// status[1:0], out_slot[13:2], out_generation[21:14], out_value[53:22],
	// live_count[66:54], zero fill above
	output      logic [OUT_DATA_W-1:0] m_tdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_MDST,
		S_WALK,
		S_WCHK
	} state_t;

	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] slot;
		logic [GEN_W-1:0]  gen;
		logic [VAL_W-1:0]  value;
		logic [SLOT_W-1:0] src;
		logic [GEN_W-1:0]  sgen;
	} req_t;

	typedef struct packed {
		logic [CNT_W-1:0]  count;
		logic [VAL_W-1:0]  value;
		logic [GEN_W-1:0]  gen;
		logic [SLOT_W-1:0] slot;
		status_t           status;
	} res_t;

	state_t            state_q, state_d;
	req_t              req_q, req_d, req_in;
	logic [CNT_W-1:0]  fresh_next_q, fresh_next_d;
	logic [CNT_W-1:0]  fresh_end_q, fresh_end_d, fe_open;
	logic [SLOT_W-1:0] head_q, head_d, tail_q, tail_d;
	logic              empty_q, empty_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [VAL_W-1:0]  srcval_q, srcval_d;
	logic [SLOT_W-1:0] node_q, node_d, slink_q, slink_d;
	logic              m_tvalid_q;
	res_t              res_q, res_d;
	logic              res_load, out_free;

	meta_req_t         meta_req;
	link_req_t         link_req;
	meta_t             meta_rd;
	logic [SLOT_W-1:0] link_rd;

	logic              src_hit, dst_hit, dst_revivable;

	ghp_store u_store (
		.clk      (clk),
		.meta_req (meta_req),
		.meta_rd  (meta_rd),
		.link_req (link_req),
		.link_rd  (link_rd)
	);

	assign req_in = {s_tdata[1:0], s_tdata[13:2], s_tdata[21:14], s_tdata[53:22],
		s_tdata[65:54], s_tdata[73:66]};

	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, res_q};

	// Slots at or above the issue mark were never written: treat them as
	// not live and not revivable, which makes every handle to them stale.
	assign src_hit = ({1'b0, req_q.src} < fresh_next_q) && meta_rd.live &&
		(meta_rd.tag == req_q.sgen);
	assign dst_hit = ({1'b0, req_q.slot} < fresh_next_q) && meta_rd.live &&
		(meta_rd.tag == req_q.gen);
	assign dst_revivable = ({1'b0, req_q.slot} < fresh_next_q) && !meta_rd.live &&
		(req_q.gen != '0) && (meta_rd.tag == bump_tag(req_q.gen));

	// Open the next chunk of never-used slots once everything else is gone.
	always_comb begin
		fe_open = fresh_end_q;
		if (fresh_next_q >= fresh_end_q && empty_q && fresh_end_q < CNT_W'(SLOTS)) begin
			if (fresh_end_q + CNT_W'(CHUNK) > CNT_W'(SLOTS)) begin
				fe_open = CNT_W'(SLOTS);
			end else begin
				fe_open = fresh_end_q + CNT_W'(CHUNK);
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		req_d        = req_q;
		fresh_next_d = fresh_next_q;
		fresh_end_d  = fresh_end_q;
		head_d       = head_q;
		tail_d       = tail_q;
		empty_d      = empty_q;
		count_d      = count_q;
		srcval_d     = srcval_q;
		node_d       = node_q;
		slink_d      = slink_q;
		meta_req     = '0;
		link_req     = '0;
		res_load     = 1'b0;
		res_d        = '0;
		res_d.status = ST_OK;

		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					// issue the read right away so the check follows next cycle
					req_d          = req_in;
					meta_req.re    = 1'b1;
					link_req.re    = 1'b1;
					link_req.raddr = head_q;
					unique case (req_in.op)
						OP_ALLOC: meta_req.raddr = head_q;
						OP_MOVE:  meta_req.raddr = req_in.src;
						default:  meta_req.raddr = req_in.slot;
					endcase
					state_d = S_CHECK;
				end
			end

			S_CHECK: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = S_IDLE;
					unique case (req_q.op)
						OP_ALLOC: begin
							fresh_end_d = fe_open;
							if (fresh_next_q < fe_open) begin
								meta_req.we    = 1'b1;
								meta_req.waddr = fresh_next_q[SLOT_W-1:0];
								meta_req.wdata = '{live: 1'b1, tag: GEN_W'(1), value: req_q.value};
								fresh_next_d   = fresh_next_q + CNT_W'(1);
								count_d        = count_q + CNT_W'(1);
								res_d.slot     = fresh_next_q[SLOT_W-1:0];
								res_d.gen      = GEN_W'(1);
							end else if (!empty_q) begin
								meta_req.we    = 1'b1;
								meta_req.waddr = head_q;
								meta_req.wdata = '{live: 1'b1, tag: meta_rd.tag, value: req_q.value};
								if (head_q == tail_q) begin
									empty_d = 1'b1;
								end else begin
									head_d = link_rd;
								end
								count_d    = count_q + CNT_W'(1);
								res_d.slot = head_q;
								res_d.gen  = meta_rd.tag;
							end else begin
								res_d.status = ST_FULL;
							end
						end
						OP_LOOKUP: begin
							if (dst_hit) begin
								res_d.value = meta_rd.value;
							end else begin
								res_d.status = ST_STALE;
							end
						end
						OP_FREE: begin
							if (dst_hit) begin
								// append to the tail and retire the generation
								if (empty_q) begin
									head_d  = req_q.slot;
									empty_d = 1'b0;
								end else begin
									link_req.we    = 1'b1;
									link_req.waddr = tail_q;
									link_req.wdata = req_q.slot;
								end
								tail_d         = req_q.slot;
								meta_req.we    = 1'b1;
								meta_req.waddr = req_q.slot;
								meta_req.wdata = '{live: 1'b0, tag: bump_tag(meta_rd.tag), value: '0};
								count_d        = count_q - CNT_W'(1);
							end else begin
								res_d.status = ST_STALE;
							end
						end
						OP_MOVE: begin
							if (!src_hit) begin
								res_d.status = ST_BAD_SRC;
							end else begin
								// hold the source word, fetch the destination
								res_load       = 1'b0;
								srcval_d       = meta_rd.value;
								meta_req.re    = 1'b1;
								meta_req.raddr = req_q.slot;
								link_req.re    = 1'b1;
								link_req.raddr = req_q.slot;
								state_d        = S_MDST;
							end
						end
					endcase
				end
			end

			S_MDST: begin
				if (out_free) begin
					state_d = S_IDLE;
					if (dst_hit) begin
						meta_req.we    = 1'b1;
						meta_req.waddr = req_q.slot;
						meta_req.wdata = '{live: 1'b1, tag: meta_rd.tag, value: srcval_q};
						res_load       = 1'b1;
					end else if (dst_revivable && !empty_q) begin
						if (head_q == req_q.slot) begin
							if (tail_q == req_q.slot) begin
								empty_d = 1'b1;
							end else begin
								head_d = link_rd;
							end
							meta_req.we    = 1'b1;
							meta_req.waddr = req_q.slot;
							meta_req.wdata = '{live: 1'b1, tag: req_q.gen, value: srcval_q};
							count_d        = count_q + CNT_W'(1);
							res_load       = 1'b1;
						end else begin
							// search for the predecessor of the destination
							node_d  = head_q;
							slink_d = link_rd;
							state_d = S_WALK;
						end
					end else begin
						res_d.status = ST_STALE;
						res_load     = 1'b1;
					end
				end
			end

			S_WALK: begin
				if (out_free) begin
					if (node_q == tail_q) begin
						res_d.status = ST_STALE;
						res_load     = 1'b1;
						state_d      = S_IDLE;
					end else begin
						link_req.re    = 1'b1;
						link_req.raddr = node_q;
						state_d        = S_WCHK;
					end
				end
			end

			S_WCHK: begin
				if (out_free) begin
					if (link_rd == req_q.slot) begin
						// splice the destination out and revive it
						link_req.we    = 1'b1;
						link_req.waddr = node_q;
						link_req.wdata = slink_q;
						if (tail_q == req_q.slot) begin
							tail_d = node_q;
						end
						meta_req.we    = 1'b1;
						meta_req.waddr = req_q.slot;
						meta_req.wdata = '{live: 1'b1, tag: req_q.gen, value: srcval_q};
						count_d        = count_q + CNT_W'(1);
						res_load       = 1'b1;
						state_d        = S_IDLE;
					end else begin
						node_d  = link_rd;
						state_d = S_WALK;
					end
				end
			end

			default: state_d = S_IDLE;
		endcase

		res_d.count = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fresh_next_q <= '0;
			fresh_end_q  <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			empty_q      <= 1'b1;
			count_q      <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q      <= state_d;
			fresh_next_q <= fresh_next_d;
			fresh_end_q  <= fresh_end_d;
			head_q       <= head_d;
			tail_q       <= tail_d;
			empty_q      <= empty_d;
			count_q      <= count_d;
			if (res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers: no reset
	always_ff @(posedge clk) begin
		req_q    <= req_d;
		srcval_q <= srcval_d;
		node_q   <= node_d;
		slink_q  <= slink_d;
		if (res_load) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

### design/ghp_checker.sv
// ----------------------------------------------------------------------------
// ghp_checker: port-level checks of the handle pool
// Watches results for consistency of status, payload, count and stall hold.
// ----------------------------------------------------------------------------
`default_nettype none

module ghp_checker
	import ghp_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic [IN_DATA_W-1:0]  s_tdata,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata
);

	logic unused_in;
	assign unused_in = s_tvalid ^ s_tready ^ (^s_tdata);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[66:54] <= CNT_W'(SLOTS))
		else $error("live count beyond slot total");

	a_full_means_all_live: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1:0] == ST_FULL) |-> m_tdata[66:54] == CNT_W'(SLOTS))
		else $error("table full reported with free slots");

	a_fail_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1:0] != ST_OK) |->
		(m_tdata[13:2] == '0 && m_tdata[21:14] == '0 && m_tdata[53:22] == '0))
		else $error("failed request carries payload");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

bind generational_handle_pool ghp_checker u_ghp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
